FILE: rtl/stepper_step_dir_pulse_generator_assert.svh
// Assertion macros used by the checker file stp_checker.sv.
`ifndef STEPPER_STEP_DIR_PULSE_GENERATOR_ASSERT_SVH
`define STEPPER_STEP_DIR_PULSE_GENERATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define STP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stp assertion failed");

// Next-cycle implication, sampled on clk, quiet during reset.
`define STP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stp assertion failed");

// Check that also runs across the reset edge.
`define STP_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("stp assertion failed");

`endif

FILE: rtl/stp_pkg.sv
package stp_pkg;

  localparam int STEP_COUNT_W        = 32;
  localparam int STEP_COUNT_BITS_DEF = 32;
  localparam int PERIOD_W            = 16;
  localparam int TICKS_W             = 16;
  // ceil(65535 / 1000) = 66 fits in 7 bits
  localparam int INTERVAL_W          = 7;
  localparam int APB_ADDR_W          = 3;
  localparam int APB_DATA_W          = 32;

  localparam logic [PERIOD_W-1:0]   PERIOD_RESET   = 16'd1000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 7'd1;
  localparam logic [PERIOD_W:0]     PERIOD_ROUND   = 17'd999;
  // floor(x / 1000) == (x * 134218) >> 27 for every x below 2^17
  localparam logic [17:0]           RECIP_MULT     = 18'd134218;
  localparam int                    RECIP_SHIFT    = 27;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_MOVE   = 2'd1,
    REQ_OSC    = 2'd2,
    REQ_ENABLE = 2'd3
  } req_t;

  typedef struct packed {
    logic step_pulse;
    logic direction_fwd;
    logic driver_enabled;
    logic is_running;
  } result_t;

endpackage

FILE: rtl/stepper_step_dir_pulse_generator.sv
// Path: an accepted input beat is held in the input register (s1); its result is loaded
// into the result register (out_res) and offered when s1 advances, and held until taken.
// Throughput: one item per cycle; the state update runs in one pass between the
// input register and the result register, and stalls only on out_ready.
// Reset (rst, synchronous): motion state clears, direction forward, driver off,
// the step period returns to 1000 us; both pipeline registers empty.
module stepper_step_dir_pulse_generator #(
  parameter int STEP_COUNT_BITS = stp_pkg::STEP_COUNT_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [1:0]                              req_type,
  input  logic signed [stp_pkg::STEP_COUNT_W-1:0] step_count,
  input  logic                                    enable_value,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic                                    step_pulse,
  output logic                                    direction_fwd,
  output logic                                    driver_enabled,
  output logic                                    is_running,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [stp_pkg::APB_ADDR_W-1:0]          paddr,
  input  logic [stp_pkg::APB_DATA_W-1:0]          pwdata,
  output logic [stp_pkg::APB_DATA_W-1:0]          prdata,
  output logic                                    pready
);
  import stp_pkg::*;

  logic                           s1_valid;
  logic [1:0]                     s1_req;
  logic signed [STEP_COUNT_W-1:0] s1_count;
  logic                           s1_enable;
  logic                           s1_adv;
  logic                           fire;
  logic [INTERVAL_W-1:0]          interval;
  result_t                        res;
  result_t                        out_res;

  assign pready   = 1'b1;
  assign s1_adv   = !out_valid || out_ready;
  assign in_ready = !s1_valid || s1_adv;
  assign fire     = s1_valid && s1_adv;

  stp_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .interval (interval)
  );

  stp_core #(
    .STEP_COUNT_BITS (STEP_COUNT_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .req_type     (s1_req),
    .step_count   (s1_count),
    .enable_value (s1_enable),
    .interval     (interval),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid <= s1_valid;
      end
    end
  end

  // payload registers: load on beat, hold otherwise
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_req    <= req_type;
      s1_count  <= step_count;
      s1_enable <= enable_value;
    end
    if (fire) begin
      out_res <= res;
    end
  end

  assign step_pulse     = out_res.step_pulse;
  assign direction_fwd  = out_res.direction_fwd;
  assign driver_enabled = out_res.driver_enabled;
  assign is_running     = out_res.is_running;

endmodule

FILE: rtl/stp_regs.sv
module stp_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [stp_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [stp_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [stp_pkg::APB_DATA_W-1:0]   prdata,
  output logic [stp_pkg::INTERVAL_W-1:0]   interval
);
  import stp_pkg::*;

  localparam int PROD_W = PERIOD_W + 1 + 18;

  logic [PERIOD_W-1:0] period_us;
  logic                reg_hit;
  logic                wr_en;
  logic [PERIOD_W:0]   rounded;
  logic [PROD_W-1:0]   prod;

  assign reg_hit = (paddr[APB_ADDR_W-1] == 1'b0);
  assign wr_en   = psel && penable && pwrite && reg_hit;

  // ceil(period / 1000) by reciprocal multiply
  assign rounded = {1'b0, pwdata[PERIOD_W-1:0]} + PERIOD_ROUND;
  assign prod    = PROD_W'(rounded) * PROD_W'(RECIP_MULT);

  always_ff @(posedge clk) begin
    if (rst) begin
      period_us <= PERIOD_RESET;
      interval  <= INTERVAL_RESET;
    end else if (wr_en) begin
      period_us <= pwdata[PERIOD_W-1:0];
      interval  <= prod[RECIP_SHIFT +: INTERVAL_W];
    end
  end

  assign prdata = reg_hit ? APB_DATA_W'(period_us) : '0;

endmodule

FILE: rtl/stp_core.sv
module stp_core #(
  parameter int STEP_COUNT_BITS = stp_pkg::STEP_COUNT_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  fire,
  input  logic [1:0]                            req_type,
  input  logic signed [stp_pkg::STEP_COUNT_W-1:0] step_count,
  input  logic                                  enable_value,
  input  logic [stp_pkg::INTERVAL_W-1:0]        interval,
  output stp_pkg::result_t                      res
);
  import stp_pkg::*;

  localparam int N    = STEP_COUNT_BITS;
  localparam int HI_W = STEP_COUNT_W - N + 1;
  localparam logic signed [N-1:0] CNT_ZERO  = '0;
  localparam logic signed [N-1:0] CNT_ONE   = {{(N-1){1'b0}}, 1'b1};
  localparam logic signed [N-1:0] CNT_M_ONE = '1;
  localparam logic signed [N-1:0] CNT_MAX   = {1'b0, {(N-1){1'b1}}};
  localparam logic signed [N-1:0] CNT_MIN   = {1'b1, {(N-1){1'b0}}};

  logic                enabled_flag, enabled_flag_next;
  logic                running_flag, running_flag_next;
  logic signed [N-1:0] steps_left, steps_left_next;
  logic                dir_forward, dir_forward_next;
  logic [TICKS_W-1:0]  ticks_since_step, ticks_since_step_next;
  logic signed [N-1:0] oscillate_target, oscillate_target_next;

  logic [HI_W-1:0]     hi_bits;
  logic                fits;
  logic signed [N-1:0] cnt;
  logic                cnt_pos, cnt_neg;
  logic [TICKS_W-1:0]  ticks_inc;
  logic signed [N-1:0] steps_dec;
  logic                pulse;

  // saturate the 32-bit count into the signed N-bit range
  assign hi_bits = step_count[STEP_COUNT_W-1:N-1];
  assign fits    = (&hi_bits) || !(|hi_bits);
  assign cnt     = fits ? step_count[N-1:0]
                        : (step_count[STEP_COUNT_W-1] ? CNT_MIN : CNT_MAX);
  assign cnt_neg = cnt[N-1];
  assign cnt_pos = !cnt[N-1] && (cnt != CNT_ZERO);

  assign ticks_inc = (&ticks_since_step) ? ticks_since_step
                                         : ticks_since_step + TICKS_W'(1);

  always_comb begin
    if (!steps_left[N-1] && steps_left != CNT_ZERO) begin
      steps_dec = steps_left - CNT_ONE;
    end else if (steps_left[N-1]) begin
      steps_dec = steps_left + CNT_ONE;
    end else begin
      steps_dec = steps_left;
    end
  end

  always_comb begin
    enabled_flag_next     = enabled_flag;
    running_flag_next     = running_flag;
    steps_left_next       = steps_left;
    dir_forward_next      = dir_forward;
    ticks_since_step_next = ticks_since_step;
    oscillate_target_next = oscillate_target;
    pulse                 = 1'b0;
    case (req_t'(req_type))
      REQ_TICK: begin
        if (enabled_flag && running_flag) begin
          ticks_since_step_next = ticks_inc;
          if (ticks_inc >= TICKS_W'(interval)) begin
            pulse                 = 1'b1;
            ticks_since_step_next = '0;
            steps_left_next       = steps_dec;
            if (steps_dec == CNT_ZERO) begin
              running_flag_next = 1'b0;
              // work the oscillate target back one step, opposite sense
              if (oscillate_target[N-1]) begin
                oscillate_target_next = oscillate_target + CNT_ONE;
                dir_forward_next      = 1'b1;
                steps_left_next       = CNT_ONE;
                running_flag_next     = 1'b1;
              end else if (oscillate_target != CNT_ZERO) begin
                oscillate_target_next = oscillate_target - CNT_ONE;
                dir_forward_next      = 1'b0;
                steps_left_next       = CNT_M_ONE;
                running_flag_next     = 1'b1;
              end
            end
          end
        end
      end
      REQ_MOVE: begin
        if (enabled_flag) begin
          if (cnt_pos) begin
            dir_forward_next = 1'b1;
          end else if (cnt_neg) begin
            dir_forward_next = 1'b0;
          end
          steps_left_next = cnt;
          if (cnt_pos || cnt_neg) begin
            running_flag_next     = 1'b1;
            ticks_since_step_next = '0;
          end
        end
      end
      REQ_OSC: begin
        oscillate_target_next = cnt;
        if (enabled_flag && (cnt_pos || cnt_neg) && !running_flag) begin
          running_flag_next     = 1'b1;
          ticks_since_step_next = '0;
          dir_forward_next      = !cnt_neg;
          steps_left_next       = cnt;
        end
      end
      REQ_ENABLE: begin
        enabled_flag_next = enable_value;
        if (!enable_value) begin
          running_flag_next = 1'b0;
          steps_left_next   = CNT_ZERO;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled_flag     <= 1'b0;
      running_flag     <= 1'b0;
      steps_left       <= CNT_ZERO;
      dir_forward      <= 1'b1;
      ticks_since_step <= '0;
      oscillate_target <= CNT_ZERO;
    end else if (fire) begin
      enabled_flag     <= enabled_flag_next;
      running_flag     <= running_flag_next;
      steps_left       <= steps_left_next;
      dir_forward      <= dir_forward_next;
      ticks_since_step <= ticks_since_step_next;
      oscillate_target <= oscillate_target_next;
    end
  end

  assign res.step_pulse     = pulse;
  assign res.direction_fwd  = dir_forward_next;
  assign res.driver_enabled = enabled_flag_next;
  assign res.is_running     = running_flag_next;

endmodule

FILE: rtl/stp_checker.sv
`include "stepper_step_dir_pulse_generator_assert.svh"

module stp_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic step_pulse,
  input logic driver_enabled,
  input logic is_running
);

  // a pulse comes only from a tick taken while the driver is on
  `STP_ASSERT_NOW(a_pulse_needs_enable, out_valid && step_pulse, driver_enabled)

  // a move never survives a disable
  `STP_ASSERT_NOW(a_run_needs_enable, out_valid && is_running, driver_enabled)

  // a stalled result beat holds
  `STP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(step_pulse) && $stable(is_running))

  // nothing is offered in the cycle after reset
  `STP_ASSERT_ALWAYS(a_reset_empty, rst, ##1 !out_valid)

endmodule

bind stepper_step_dir_pulse_generator stp_checker u_stp_checker (.*);
